### src/slu_pkg.sv
// Shared types, character codes and decode helpers for the string literal unescaper.
`timescale 1ns / 1ps

package slu_pkg;

    // Result kinds
    localparam logic [1:0] KIND_BYTE = 2'd0;
    localparam logic [1:0] KIND_OK   = 2'd1;
    localparam logic [1:0] KIND_BAD  = 2'd2;

    // Characters that steer the decoder
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_X     = 8'h78;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_SEVEN = 8'h37;

    // Largest value an escape may hold
    localparam logic [11:0] ESC_MAX = 12'd255;

    // One result beat
    typedef struct packed {
        logic [7:0] byte_val;
        logic [1:0] kind;
    } slu_result_t;

    // One queue entry: the results caused by one input character
    typedef struct packed {
        logic        two;
        slu_result_t first;
        slu_result_t second;
    } slu_entry_t;

    // Hex digit value; valid flag in the top bit
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 4'(c - 8'h30)};
        end
        else if (c >= 8'h61 && c <= 8'h66) begin
            r = {1'b1, 4'(c - 8'h57)};
        end
        else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b1, 4'(c - 8'h37)};
        end
        return r;
    endfunction

    // Simple escape mapping; unknown characters map to themselves
    function automatic logic [7:0] simple_escape(input logic [7:0] c);
        logic [7:0] r;
        unique case (c)
            8'h27:   r = 8'd39;
            8'h22:   r = 8'd34;
            8'h5C:   r = 8'd92;
            8'h61:   r = 8'd7;
            8'h62:   r = 8'd8;
            8'h65:   r = 8'd27;
            8'h66:   r = 8'd12;
            8'h6E:   r = 8'd10;
            8'h72:   r = 8'd13;
            8'h74:   r = 8'd9;
            8'h76:   r = 8'd11;
            8'h3F:   r = 8'd63;
            default: r = c;
        endcase
        return r;
    endfunction

endpackage

### src/slu_front.sv
// Front end: accepts characters, tracks literal phase and escape value, builds result entries.
`timescale 1ns / 1ps

module slu_front
    import slu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] char_in,
    input  logic       is_last,
    output logic       entry_push,
    output slu_entry_t entry
);

    typedef enum logic [2:0] {
        PH_OPEN = 3'd0,
        PH_BODY = 3'd1,
        PH_ESC  = 3'd2,
        PH_HEX  = 3'd3,
        PH_OCT  = 3'd4,
        PH_SKIP = 3'd5
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [7:0]  esc_reg, esc_next;

    // Body character outcome
    logic        body_emit;
    slu_result_t body_res;
    phase_t      body_phase;

    // Digit handling
    logic [4:0]  hd;
    logic        is_hex;
    logic        digit_ok;
    logic [11:0] nv;

    logic [1:0]  n;
    slu_result_t r0, r1;

    // Judge a character as part of the literal body
    always_comb
    begin
        body_emit  = 1'b1;
        body_res   = '{byte_val: 8'd0, kind: KIND_BAD};
        body_phase = PH_BODY;
        if (is_last) begin
            body_res.kind = (char_in == CH_QUOTE) ? KIND_OK : KIND_BAD;
            body_phase    = PH_OPEN;
        end
        else if (char_in == CH_BSL) begin
            body_emit  = 1'b0;
            body_phase = PH_ESC;
        end
        else begin
            body_res = '{byte_val: char_in, kind: KIND_BYTE};
        end
    end

    // Grow the escape value by one digit
    always_comb
    begin
        hd       = hex_digit(char_in);
        is_hex   = (phase_reg == PH_HEX);
        digit_ok = hd[4] && (is_hex || !hd[3]);
        nv       = is_hex ? ({esc_reg, 4'd0} + {8'd0, hd[3:0]})
                          : ({1'b0, esc_reg, 3'd0} + {8'd0, hd[3:0]});
    end

    // Classify the character and pick the next state
    always_comb
    begin
        phase_next = phase_reg;
        esc_next   = esc_reg;
        n          = 2'd0;
        r0         = '{byte_val: 8'd0, kind: KIND_BAD};
        r1         = '{byte_val: 8'd0, kind: KIND_BAD};
        unique case (phase_reg)
            PH_BODY:
            begin
                n          = {1'b0, body_emit};
                r0         = body_res;
                phase_next = body_phase;
            end
            PH_ESC:
            begin
                if (is_last) begin
                    n          = 2'd1;
                    phase_next = PH_OPEN;
                end
                else if (char_in == CH_X) begin
                    esc_next   = 8'd0;
                    phase_next = PH_HEX;
                end
                else if (char_in >= CH_ZERO && char_in <= CH_SEVEN) begin
                    esc_next   = 8'(char_in - CH_ZERO);
                    phase_next = PH_OCT;
                end
                else begin
                    n          = 2'd1;
                    r0         = '{byte_val: simple_escape(char_in), kind: KIND_BYTE};
                    phase_next = PH_BODY;
                end
            end
            PH_HEX, PH_OCT:
            begin
                if (!is_last && digit_ok && nv <= ESC_MAX) begin
                    esc_next = nv[7:0];
                end
                else begin
                    r0         = '{byte_val: esc_reg, kind: KIND_BYTE};
                    r1         = body_res;
                    n          = body_emit ? 2'd2 : 2'd1;
                    esc_next   = 8'd0;
                    phase_next = body_phase;
                end
            end
            PH_SKIP:
            begin
                if (is_last) begin
                    n          = 2'd1;
                    phase_next = PH_OPEN;
                end
            end
            default:
            begin
                esc_next = 8'd0;
                if (is_last) begin
                    n          = 2'd1;
                    phase_next = PH_OPEN;
                end
                else if (char_in == CH_QUOTE) begin
                    phase_next = PH_BODY;
                end
                else begin
                    phase_next = PH_SKIP;
                end
            end
        endcase
    end

    assign entry_push   = accept && (n != 2'd0);
    assign entry.two    = n[1];
    assign entry.first  = r0;
    assign entry.second = r1;

    // Hold state; advance on each accepted beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg <= PH_OPEN;
            esc_reg   <= 8'd0;
        end
        else if (accept) begin
            phase_reg <= phase_next;
            esc_reg   <= esc_next;
        end
    end

endmodule

### src/slu_queue.sv
// Short entry queue between the front end and the back end.
`timescale 1ns / 1ps

module slu_queue
    import slu_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       wr_en,
    input  slu_entry_t wr_data,
    input  logic       rd_en,
    output slu_entry_t rd_data,
    output logic       full,
    output logic       not_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    slu_entry_t        mem [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign rd_data   = mem[rd_ptr_reg];

    // Store entries
    always_ff @(posedge clk)
    begin
        if (wr_en) begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    // Advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            if (wr_en) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(wr_ptr_reg + 1'b1);
            end
            if (rd_en) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(rd_ptr_reg + 1'b1);
            end
            if (wr_en && !rd_en) begin
                count_reg <= CNT_W'(count_reg + 1'b1);
            end
            else if (!wr_en && rd_en) begin
                count_reg <= CNT_W'(count_reg - 1'b1);
            end
        end
    end

endmodule

### src/slu_back.sv
// Back end: splits queue entries into single result beats behind an output register.
`timescale 1ns / 1ps

module slu_back
    import slu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       entry_avail,
    input  slu_entry_t entry,
    output logic       entry_pop,
    output logic [7:0] byte_out,
    output logic [1:0] kind,
    output logic       last_of_run,
    output logic       empty,
    input  logic       pop
);

    logic        out_valid_reg;
    logic        second_reg;
    slu_result_t out_res_reg;
    logic        out_last_reg;
    logic        load;
    logic        take_second;
    logic        more;

    // Load the output register when it is free or being drained
    assign load        = entry_avail && (!out_valid_reg || pop);
    assign take_second = second_reg;
    assign more        = entry.two && !second_reg;
    assign entry_pop   = load && !more;

    assign byte_out    = out_res_reg.byte_val;
    assign kind        = out_res_reg.kind;
    assign last_of_run = out_last_reg;
    assign empty       = !out_valid_reg;

    // Hold output payload
    always_ff @(posedge clk)
    begin
        if (load) begin
            out_res_reg  <= take_second ? entry.second : entry.first;
            out_last_reg <= !more;
        end
    end

    // Track output valid and which half of the entry is next
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
            second_reg    <= 1'b0;
        end
        else begin
            if (load) begin
                out_valid_reg <= 1'b1;
                second_reg    <= more;
            end
            else if (pop) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

### src/string_literal_unescaper_unit.sv
// Top level of the string literal unescaper.
//
// Input channel: one literal character per beat on char_in, is_last set on
// the closing character. A beat is taken when push is high and full is low.
// Output channel: decoded results, oldest first. While empty is low the
// result on byte_out/kind/last_of_run is valid; pop with empty low takes it.
// kind is byte, literal ok or malformed; last_of_run marks the final result
// caused by one input character.
// A character's results are written into the queue when its beat is accepted
// and are then loaded into the output register, which presents them.
// Throughput: one character per cycle while full is low and each makes
// at most one result; a character that closes a numeric escape makes two
// unless it is a backslash; the output register then presents them in turn.
// A queue of QUEUE_DEPTH entries between front and back end absorbs stalls;
// when the receiver holds pop low the queue fills and full rises.
// Reset clears the queue and output register and expects an opening quote.
`timescale 1ns / 1ps

module string_literal_unescaper_unit
    import slu_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [7:0] char_in,
    input  logic       is_last,
    input  logic       push,
    output logic       full,
    output logic [7:0] byte_out,
    output logic [1:0] kind,
    output logic       last_of_run,
    output logic       empty,
    input  logic       pop
);

    logic       accept;
    logic       entry_push;
    slu_entry_t entry_in;
    slu_entry_t entry_head;
    logic       entry_avail;
    logic       entry_pop;

    assign accept = push && !full;

    slu_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .char_in    (char_in),
        .is_last    (is_last),
        .entry_push (entry_push),
        .entry      (entry_in)
    );

    slu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (entry_push),
        .wr_data   (entry_in),
        .rd_en     (entry_pop),
        .rd_data   (entry_head),
        .full      (full),
        .not_empty (entry_avail)
    );

    slu_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .entry_avail (entry_avail),
        .entry       (entry_head),
        .entry_pop   (entry_pop),
        .byte_out    (byte_out),
        .kind        (kind),
        .last_of_run (last_of_run),
        .empty       (empty),
        .pop         (pop)
    );

endmodule
